// ----- hdl/jfwd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfwd_pkg
// Types, constants and pin tables shared by the four-wheel-drive sequencer.
// ----------------------------------------------------------------------------
package jfwd_pkg;

  localparam int unsigned CmpW   = 15;
  localparam int unsigned PinW   = 8;
  localparam int unsigned MagW   = 8;
  localparam int unsigned SeqLen = 4;
  localparam int unsigned CntW   = $clog2(SeqLen + 1);

  localparam logic [CmpW-1:0] SPEED_SCALE = 15'd200;
  localparam logic [MagW-1:0] MAG_FULL    = 8'd128;
  localparam logic [6:0]      MAG_CLAMP   = 7'd127;
  localparam logic [CmpW-1:0] DUTY_RESET  = 15'd20000;
  localparam logic [CmpW-1:0] DUTY_MAX    = 15'd25599;

  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_BACK  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    ROT_CW   = 2'd0,
    ROT_CCW  = 2'd1,
    ROT_NONE = 2'd2
  } rot_t;

  typedef enum logic {
    ACT_CMP  = 1'b0,
    ACT_PINS = 1'b1
  } act_t;

  typedef struct packed {
    logic            left_x_sign;
    logic            left_y_sign;
    logic [MagW-1:0] left_x_mag;
    logic [MagW-1:0] left_y_mag;
    logic            right_x_sign;
    logic [MagW-1:0] right_x_mag;
  } joy_t;

  typedef struct packed {
    act_t            action;
    logic [CmpW-1:0] compare_value;
    logic [PinW-1:0] wheel_pins;
  } seq_ent_t;

  localparam seq_ent_t ENT_ZERO = '{action: ACT_CMP, compare_value: '0, wheel_pins: '0};

  typedef struct packed {
    logic [CntW-1:0]        cnt;
    seq_ent_t [SeqLen-1:0]  ent;
    dir_t                   dir;
    logic [CmpW-1:0]        speed;
    rot_t                   rot;
  } plan_t;

  typedef struct packed {
    dir_t            dir;
    logic [CmpW-1:0] speed;
    rot_t            rot;
  } drv_state_t;

  function automatic logic [CmpW-1:0] mag_to_speed(input logic [MagW-1:0] mag);
    logic [6:0] m;
    m = (mag >= MAG_FULL) ? MAG_CLAMP : mag[6:0];
    return CmpW'({8'd0, m} * SPEED_SCALE);
  endfunction

  function automatic logic [PinW-1:0] dir_pins(input dir_t d);
    logic [PinW-1:0] p;
    case (d)
      DIR_FWD:   p = 8'h55;
      DIR_BACK:  p = 8'hAA;
      DIR_LEFT:  p = 8'h5A;
      DIR_RIGHT: p = 8'hA5;
      default:   p = 8'hFF;
    endcase
    return p;
  endfunction

  function automatic logic [PinW-1:0] rot_pins(input rot_t r);
    logic [PinW-1:0] p;
    case (r)
      ROT_CCW: p = 8'h99;
      default: p = 8'h66;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/jfwd_plan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jfwd_plan
// Decodes one joystick reading against the stored drive state into the list
// of compare and pin writes, plus the new drive state.
// ----------------------------------------------------------------------------
module jfwd_plan (
  input  wire jfwd_pkg::joy_t           joy,
  input  wire jfwd_pkg::drv_state_t     prev,
  input  wire logic [jfwd_pkg::CmpW-1:0] rotate_duty,
  output jfwd_pkg::plan_t               plan
);
  import jfwd_pkg::*;

  dir_t            dir;
  logic [CmpW-1:0] speed;
  rot_t            rot;
  logic [CmpW-1:0] duty_sat;
  logic            prefix;
  logic [1:0]      tail_cnt;
  seq_ent_t        t0, t1, t2;
  seq_ent_t        pin_ent, spd_ent;

  always_comb begin
    if (joy.left_x_mag < joy.left_y_mag) begin
      dir   = joy.left_y_sign ? DIR_BACK : DIR_FWD;
      speed = mag_to_speed(joy.left_y_mag);
    end else if (joy.left_x_mag > joy.left_y_mag) begin
      dir   = joy.left_x_sign ? DIR_RIGHT : DIR_LEFT;
      speed = mag_to_speed(joy.left_x_mag);
    end else if (joy.left_x_mag == '0) begin
      dir   = DIR_STOP;
      speed = '0;
    end else begin
      // equal nonzero deflection keeps the last motion
      dir   = prev.dir;
      speed = prev.speed;
    end
    rot      = (joy.right_x_mag != '0) ? (joy.right_x_sign ? ROT_CCW : ROT_CW) : ROT_NONE;
    duty_sat = (rotate_duty > DUTY_MAX) ? DUTY_MAX : rotate_duty;
  end

  always_comb begin
    prefix   = 1'b0;
    tail_cnt = 2'd0;
    pin_ent  = ENT_ZERO;
    spd_ent  = ENT_ZERO;
    t0       = ENT_ZERO;
    t1       = ENT_ZERO;
    t2       = ENT_ZERO;
    if (rot == ROT_NONE) begin
      prefix             = (prev.rot != ROT_NONE);
      spd_ent.compare_value = speed;
      if (dir == prev.dir) begin
        if (speed != prev.speed) begin
          tail_cnt = 2'd1;
          t0       = spd_ent;
        end
      end else begin
        pin_ent.action     = ACT_PINS;
        pin_ent.wheel_pins = dir_pins(dir);
        tail_cnt = 2'd3;
        t1       = pin_ent;
        t2       = spd_ent;
      end
    end else if (rot != prev.rot) begin
      pin_ent.action        = ACT_PINS;
      pin_ent.wheel_pins    = rot_pins(rot);
      spd_ent.compare_value = duty_sat;
      tail_cnt = 2'd3;
      t1       = pin_ent;
      t2       = spd_ent;
    end
  end

  always_comb begin
    plan.dir   = dir;
    plan.speed = speed;
    plan.rot   = rot;
    if (prefix) begin
      // leading compare-zero write stops the rotation first
      plan.ent = {t2, t1, t0, ENT_ZERO};
      plan.cnt = CntW'(tail_cnt) + CntW'(1);
    end else begin
      plan.ent = {ENT_ZERO, t2, t1, t0};
      plan.cnt = CntW'(tail_cnt);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/joystick_four_wheel_drive_sequencer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_four_wheel_drive_sequencer_unit
// Turns joystick readings into PWM compare and wheel H-bridge pin writes.
// ----------------------------------------------------------------------------
// A reading is registered, decoded combinationally against the stored drive
// state and loaded as zero to four writes into a four-entry result shift
// register, which hands out one write per cycle while out_tready is high,
// with tlast on the final one. The next reading is decoded in the cycle its
// predecessor's last write is taken; the input register can hold it while the
// result shift register drains. The first output beat passes the input
// register and the result shift register, and waits while the buffer is busy.
module joystick_four_wheel_drive_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // left_x_sign, left_y_sign, left_x_mag[7:0], left_y_mag[7:0],
  // right_x_sign, right_x_mag[7:0], zero pad
  input  wire logic [31:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // compare_value[14:0], wheel_pins[7:0], zero pad
  output logic [23:0]      out_tdata,
  output logic             out_tuser,   // action
  output logic             out_tlast,   // last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [14:0] cfg_data,    // rotate_duty
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);
  import jfwd_pkg::*;

  joy_t                  joy_r;
  logic                  in_vld_r;
  drv_state_t            drv_r, drv_nxt;
  logic [CmpW-1:0]       duty_r;
  seq_ent_t [SeqLen-1:0] ent_r, ent_nxt;
  logic [CntW-1:0]       rem_r, rem_nxt;
  plan_t                 plan;
  logic                  out_fire;
  logic                  buf_free;
  logic                  load;

  jfwd_plan u_plan (
    .joy         (joy_r),
    .prev        (drv_r),
    .rotate_duty (duty_r),
    .plan        (plan)
  );

  assign cfg_ready = 1'b1;
  assign out_fire  = out_tvalid && out_tready;
  assign buf_free  = (rem_r == '0) || ((rem_r == CntW'(1)) && out_tready);
  assign load      = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || load;

  assign out_tvalid = (rem_r != '0);
  assign out_tlast  = (rem_r == CntW'(1));
  assign out_tuser  = ent_r[0].action;
  assign out_tdata  = {1'b0, ent_r[0].wheel_pins, ent_r[0].compare_value};

  always_comb begin
    ent_nxt = ent_r;
    rem_nxt = rem_r;
    drv_nxt = drv_r;
    if (load) begin
      ent_nxt = plan.ent;
      rem_nxt = plan.cnt;
      drv_nxt = '{dir: plan.dir, speed: plan.speed, rot: plan.rot};
    end else if (out_fire) begin
      ent_nxt = {ENT_ZERO, ent_r[SeqLen-1:1]};
      rem_nxt = rem_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      rem_r    <= '0;
      drv_r    <= '{dir: DIR_FWD, speed: '0, rot: ROT_NONE};
      duty_r   <= DUTY_RESET;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      rem_r <= rem_nxt;
      drv_r <= drv_nxt;
      if (cfg_valid && cfg_ready) duty_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      joy_r <= '{left_x_sign:  in_tdata[0],
                 left_y_sign:  in_tdata[1],
                 left_x_mag:   in_tdata[9:2],
                 left_y_mag:   in_tdata[17:10],
                 right_x_sign: in_tdata[18],
                 right_x_mag:  in_tdata[26:19]};
    end
    ent_r <= ent_nxt;
  end

  // pin beats never carry a compare value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[14:0] == '0)
    else $error("pin beat with nonzero compare value");

  // compare beats stay inside the timer range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[14:0] <= DUTY_MAX && out_tdata[22:15] == '0)
    else $error("compare beat out of range");

  // the final beat of a reading empties the buffer unless a new plan loads
  assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast && !load |=> !out_tvalid)
    else $error("beats after tlast");

  assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= CntW'(SeqLen))
    else $error("result count overflow");

  // a waiting reading is decoded as soon as the buffer drains
  assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_tvalid |=> !in_vld_r || $past(in_tvalid && in_tready))
    else $error("reading stuck in input register");

endmodule
`default_nettype wire
